/* sv/rihc_pkg.sv */
// ----------------------------------------------------------------------------
// rihc_pkg
// Shared types and constants of the cartridge image header checker: CRC-32
// constants, header layout, verdict codes and configuration register indexes.
// ----------------------------------------------------------------------------
package rihc_pkg;

  // reflected crc-32
  localparam logic [31:0] CRC_POLY   = 32'hedb8_8320;
  localparam logic [31:0] CRC_PRESET = 32'hffff_ffff;

  // header bytes kept from the start of the image
  localparam int unsigned HDR_KEPT  = 10;
  localparam int unsigned HDR_IDX_W = 4;
  localparam int unsigned MIN_IMAGE = 16;

  // magic word at the head of the image
  localparam logic [7:0] MAGIC_0 = 8'h4e;
  localparam logic [7:0] MAGIC_1 = 8'h45;
  localparam logic [7:0] MAGIC_2 = 8'h53;
  localparam logic [7:0] MAGIC_3 = 8'h1a;

  // size fields
  localparam int unsigned PRG_W        = 26;
  localparam int unsigned CHR_W        = 25;
  localparam int unsigned NEED_W       = 27;
  localparam logic [PRG_W-1:0] NEEDED_PRG    = 26'd32768;
  localparam logic [NEED_W-1:0] TRAINER_BYTES = 27'd512;
  localparam logic [NEED_W-1:0] HEADER_BYTES  = 27'd16;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_CRC    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_MAPPER = 8'd1;

  // register reset values
  localparam logic [31:0] EXPECTED_CRC_RST    = 32'hd16e_a396;
  localparam logic [11:0] REQUIRED_MAPPER_RST = 12'd1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TOO_SMALL   = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_OVERRUN     = 3'd3,
    ST_UNSUPPORTED = 3'd4
  } status_e;

  typedef logic [HDR_KEPT-1:0][7:0] header_t;

  // end-of-image snapshot handed to the verdict stage
  typedef struct packed {
    logic [31:0] crc;
    header_t     header;
  } snap_t;

  // verdict word, length travels beside it
  typedef struct packed {
    status_e          status;
    logic             format_two;
    logic [11:0]      mapper_number;
    logic             has_trainer;
    logic [PRG_W-1:0] program_bytes;
    logic [CHR_W-1:0] pattern_bytes;
    logic [31:0]      image_crc;
    logic             crc_matches;
  } result_t;

  // one byte of the reflected crc, bit steps unrolled
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

/* sv/rihc_stream.sv */
// ----------------------------------------------------------------------------
// rihc_stream
// Per-byte stream state: running CRC, saturating byte count and header bytes.
// On the last byte it loads a snapshot register for the verdict stage.
// ----------------------------------------------------------------------------
module rihc_stream import rihc_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 27
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             image_byte_i,
  input  logic                   is_last_i,
  output logic                   snap_valid_o,
  input  logic                   snap_ready_i,
  output snap_t                  snap_o,
  output logic [LENGTH_BITS-1:0] snap_len_o
);

  logic [31:0]            crc_q, crc_d;
  logic [LENGTH_BITS-1:0] count_q, count_d;
  header_t                header_q, header_d;
  logic                   snap_valid_q;
  snap_t                  snap_q;
  logic [LENGTH_BITS-1:0] snap_len_q;
  logic                   accept;

  assign in_ready_o = !snap_valid_q || snap_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // next stream values for the incoming word
  always_comb begin
    crc_d    = crc_byte(crc_q, image_byte_i);
    count_d  = (count_q == '1) ? count_q : count_q + LENGTH_BITS'(1);
    header_d = header_q;
    if (count_q < LENGTH_BITS'(HDR_KEPT)) begin
      header_d[count_q[HDR_IDX_W-1:0]] = image_byte_i;
    end
  end

  // crc and count, restarted after the last word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CRC_PRESET;
      count_q <= '0;
    end else if (accept) begin
      if (is_last_i) begin
        crc_q   <= CRC_PRESET;
        count_q <= '0;
      end else begin
        crc_q   <= crc_d;
        count_q <= count_d;
      end
    end
  end

  // snapshot handshake toward the verdict stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (accept && is_last_i) begin
      snap_valid_q <= 1'b1;
    end else if (snap_ready_i) begin
      snap_valid_q <= 1'b0;
    end
  end

  // header bytes and snapshot payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      header_q <= header_d;
    end
    if (accept && is_last_i) begin
      snap_q.crc    <= ~crc_d;
      snap_q.header <= header_d;
      snap_len_q    <= count_d;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;
  assign snap_len_o   = snap_len_q;

endmodule

/* sv/rihc_verdict.sv */
// ----------------------------------------------------------------------------
// rihc_verdict
// Decodes the header snapshot into the verdict and holds it in the result
// register until the consumer takes it.
// ----------------------------------------------------------------------------
module rihc_verdict import rihc_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 27
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   snap_valid_i,
  output logic                   snap_ready_o,
  input  snap_t                  snap_i,
  input  logic [LENGTH_BITS-1:0] snap_len_i,
  input  logic [31:0]            expected_crc_i,
  input  logic [11:0]            required_mapper_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output result_t                result_o,
  output logic [LENGTH_BITS-1:0] length_o
);

  logic                   out_valid_q;
  result_t                result_q, result_d;
  logic [LENGTH_BITS-1:0] length_q;
  header_t                h;
  logic                   too_small, magic_ok, fmt2, trainer;
  logic [11:0]            mapper, prg_units, chr_units;
  logic [PRG_W-1:0]       prg;
  logic [CHR_W-1:0]       chr;
  logic [NEED_W-1:0]      need;
  logic                   overrun, unsupported;

  assign h            = snap_i.header;
  assign snap_ready_o = !out_valid_q || out_ready_i;

  // header field decode
  always_comb begin
    too_small = snap_len_i < LENGTH_BITS'(MIN_IMAGE);
    magic_ok  = (h[0] == MAGIC_0) && (h[1] == MAGIC_1) &&
                (h[2] == MAGIC_2) && (h[3] == MAGIC_3);
    fmt2      = (h[7][3:2] == 2'b10);
    mapper    = {(fmt2 ? h[8][3:0] : 4'd0), h[7][7:4], h[6][7:4]};
    trainer   = h[6][2];
    // exponent size form keeps the plain byte count
    prg_units = (fmt2 && (h[9][3:0] != 4'hf)) ? {h[9][3:0], h[4]} : {4'd0, h[4]};
    chr_units = (fmt2 && (h[9][7:4] != 4'hf)) ? {h[9][7:4], h[5]} : {4'd0, h[5]};
    prg       = {prg_units, 14'd0};
    chr       = {chr_units, 13'd0};
    need      = HEADER_BYTES + (trainer ? TRAINER_BYTES : '0) +
                NEED_W'(prg) + NEED_W'(chr);
    overrun   = 33'(need) > 33'(snap_len_i);
    unsupported = (mapper != required_mapper_i) || (prg != NEEDED_PRG) ||
                  (chr_units == 12'd0);
  end

  // verdict selection
  always_comb begin
    result_d               = '0;
    result_d.image_crc     = snap_i.crc;
    result_d.crc_matches   = (snap_i.crc == expected_crc_i);
    priority if (too_small) begin
      result_d.status = ST_TOO_SMALL;
    end else if (!magic_ok) begin
      result_d.status = ST_BAD_MAGIC;
    end else begin
      result_d.format_two    = fmt2;
      result_d.mapper_number = mapper;
      result_d.has_trainer   = trainer;
      result_d.program_bytes = prg;
      result_d.pattern_bytes = chr;
      if (overrun) begin
        result_d.status = ST_OVERRUN;
      end else if (unsupported) begin
        result_d.status = ST_UNSUPPORTED;
      end else begin
        result_d.status = ST_OK;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (snap_ready_o) begin
      out_valid_q <= snap_valid_i;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (snap_valid_i && snap_ready_o) begin
      result_q <= result_d;
      length_q <= snap_len_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
  assign length_o    = length_q;

endmodule

/* sv/rom_image_header_check.sv */
// ----------------------------------------------------------------------------
// rom_image_header_check
// Streaming check of a cartridge image: CRC-32, header decode and verdict.
// ----------------------------------------------------------------------------
// Bytes of the image enter one word per cycle in file order, with is_last_i on
// the final byte. The CRC step, header capture and byte count each finish in
// the cycle of acceptance, so a new word is taken every cycle. The exception is
// when the snapshot register and the result register both hold verdicts that
// the consumer has not yet taken; input then waits until out_ready_i frees one.
// Only the last byte of an image yields a result word. That word passes through
// the snapshot register, then the result register, before it is valid on the
// output, and the next image may stream in meanwhile.
// The running CRC-32 and count restart after every last byte. The byte count
// saturates at LENGTH_BITS ones and the size check uses the saturated value.
// Registers: index 0 expected CRC, index 1 required mapper; other indexes are
// ignored. Write them while idle.
// ----------------------------------------------------------------------------
module rom_image_header_check import rihc_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 27
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // image byte channel
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             image_byte_i,
  input  logic                   is_last_i,
  // verdict channel
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2:0]             status_o,
  output logic                   format_two_o,
  output logic [11:0]            mapper_number_o,
  output logic                   has_trainer_o,
  output logic [PRG_W-1:0]       program_bytes_o,
  output logic [CHR_W-1:0]       pattern_bytes_o,
  output logic [31:0]            image_crc_o,
  output logic                   crc_matches_o,
  output logic [LENGTH_BITS-1:0] image_length_o,
  // configuration write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]            cfg_data_i
);

  logic [31:0]            expected_crc_q;
  logic [11:0]            required_mapper_q;
  logic                   snap_valid, snap_ready;
  snap_t                  snap;
  logic [LENGTH_BITS-1:0] snap_len;
  result_t                result;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_crc_q    <= EXPECTED_CRC_RST;
      required_mapper_q <= REQUIRED_MAPPER_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_EXPECTED_CRC) begin
        expected_crc_q <= cfg_data_i;
      end else if (cfg_index_i == REG_REQUIRED_MAPPER) begin
        required_mapper_q <= cfg_data_i[11:0];
      end
    end
  end

  // byte stream state and snapshot
  rihc_stream #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_stream (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .image_byte_i (image_byte_i),
    .is_last_i    (is_last_i),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap),
    .snap_len_o   (snap_len)
  );

  // header decode and result register
  rihc_verdict #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_verdict (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .snap_valid_i      (snap_valid),
    .snap_ready_o      (snap_ready),
    .snap_i            (snap),
    .snap_len_i        (snap_len),
    .expected_crc_i    (expected_crc_q),
    .required_mapper_i (required_mapper_q),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .result_o          (result),
    .length_o          (image_length_o)
  );

  assign status_o        = result.status;
  assign format_two_o    = result.format_two;
  assign mapper_number_o = result.mapper_number;
  assign has_trainer_o   = result.has_trainer;
  assign program_bytes_o = result.program_bytes;
  assign pattern_bytes_o = result.pattern_bytes;
  assign image_crc_o     = result.image_crc;
  assign crc_matches_o   = result.crc_matches;

  // a last word always leaves a snapshot behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && is_last_i |=> snap_valid)
    else $error("last word did not load the snapshot");

  // an accepted image declares the required mapper
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_OK) |-> mapper_number_o == required_mapper_q)
    else $error("ok verdict with a foreign mapper");

  // rejected before decode means no header fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == ST_TOO_SMALL) || (status_o == ST_BAD_MAGIC)) |->
      (program_bytes_o == '0) && (pattern_bytes_o == '0) && (mapper_number_o == '0))
    else $error("header fields reported for an undecoded image");

  // too small only for images under sixteen bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_TOO_SMALL) |->
      image_length_o < LENGTH_BITS'(MIN_IMAGE))
    else $error("too small verdict for a full-size image");

endmodule
